// ===== src/ccce_pkg.sv =====
// shared types and constants for the cube corner component edges block
package ccce_pkg;

    localparam int NumCorners   = 8;
    localparam int HalfCorners  = 4;
    localparam int SampleW      = 16;
    localparam int CornerW      = 3;
    localparam int CompW        = 2;
    localparam int NbrW         = 2;
    localparam int StackDepth   = 4;
    localparam int SpW          = 2;
    localparam int IdxW         = 4;

    typedef logic signed [SampleW-1:0] t_sample;

    // micro program counter, one code per step of the program
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_SCAN,
        S_TEST,
        S_WALK,
        S_FLUSH
    } t_upc;

    // datapath operation of a step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLASS,
        OP_START,
        OP_WALK,
        OP_FLUSH
    } t_uop;

    // jump condition of a step
    typedef enum logic [2:0] {
        C_IN_VALID,
        C_UNIFORM,
        C_SCAN_END,
        C_CAND,
        C_COMP_DONE,
        C_FLUSHED
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  jump_to;
        t_upc  next;
    } t_uword;

    // status flags from the datapath, sampled by the jump logic
    typedef struct packed {
        logic in_valid;
        logic uniform;
        logic scan_end;
        logic cand;
        logic comp_done;
        logic flushed;
    } t_status;

    typedef struct packed {
        logic [CompW-1:0]   comp;
        logic [CornerW-1:0] act;
        logic [CornerW-1:0] inact;
    } t_edge;

endpackage

// ===== src/ccce_useq.sv =====
// micro sequencer: control store, program counter and conditional jumps
module ccce_useq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccce_pkg::t_status  i_status,
    output ccce_pkg::t_uop     o_op
);

    ccce_pkg::t_upc   r_upc;
    ccce_pkg::t_upc   n_upc;
    ccce_pkg::t_uword w_uword;
    logic             w_take;

    // control store
    function automatic ccce_pkg::t_uword rom(input ccce_pkg::t_upc pc);
        ccce_pkg::t_uword w;
        unique case (pc)
            ccce_pkg::S_IDLE:  w = '{ccce_pkg::OP_LOAD,  ccce_pkg::C_IN_VALID,
                                     ccce_pkg::S_CLASS,  ccce_pkg::S_IDLE};
            ccce_pkg::S_CLASS: w = '{ccce_pkg::OP_CLASS, ccce_pkg::C_UNIFORM,
                                     ccce_pkg::S_IDLE,   ccce_pkg::S_SCAN};
            ccce_pkg::S_SCAN:  w = '{ccce_pkg::OP_NONE,  ccce_pkg::C_SCAN_END,
                                     ccce_pkg::S_FLUSH,  ccce_pkg::S_TEST};
            ccce_pkg::S_TEST:  w = '{ccce_pkg::OP_START, ccce_pkg::C_CAND,
                                     ccce_pkg::S_WALK,   ccce_pkg::S_SCAN};
            ccce_pkg::S_WALK:  w = '{ccce_pkg::OP_WALK,  ccce_pkg::C_COMP_DONE,
                                     ccce_pkg::S_SCAN,   ccce_pkg::S_WALK};
            ccce_pkg::S_FLUSH: w = '{ccce_pkg::OP_FLUSH, ccce_pkg::C_FLUSHED,
                                     ccce_pkg::S_IDLE,   ccce_pkg::S_FLUSH};
            default:           w = '{ccce_pkg::OP_NONE,  ccce_pkg::C_FLUSHED,
                                     ccce_pkg::S_IDLE,   ccce_pkg::S_IDLE};
        endcase
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ccce_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        w_uword = rom(r_upc);
        unique case (w_uword.cond)
            ccce_pkg::C_IN_VALID:  w_take = i_status.in_valid;
            ccce_pkg::C_UNIFORM:   w_take = i_status.uniform;
            ccce_pkg::C_SCAN_END:  w_take = i_status.scan_end;
            ccce_pkg::C_CAND:      w_take = i_status.cand;
            ccce_pkg::C_COMP_DONE: w_take = i_status.comp_done;
            ccce_pkg::C_FLUSHED:   w_take = i_status.flushed;
            default:               w_take = 1'b0;
        endcase
        n_upc = w_take ? w_uword.jump_to : w_uword.next;
        o_op  = w_uword.op;
    end

endmodule

// ===== src/ccce_dpath.sv =====
// datapath: corner classes, walk stack, pending edge and output register
module ccce_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ccce_pkg::t_uop                i_op,
    input  logic                          i_in_valid,
    input  ccce_pkg::t_sample             i_corner [ccce_pkg::NumCorners],
    input  logic                          i_cfg_valid,
    input  ccce_pkg::t_sample             i_cfg_data,
    input  logic                          i_out_ready,
    output ccce_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output ccce_pkg::t_edge               o_out_edge,
    output logic                          o_out_last
);

    localparam int CntW = $clog2(ccce_pkg::NumCorners + 1);

    ccce_pkg::t_sample r_iso;
    logic [ccce_pkg::NumCorners-1:0] r_act, n_act;
    logic [ccce_pkg::NumCorners-1:0] r_seen, n_seen;
    logic                            r_want, n_want;
    logic [ccce_pkg::IdxW-1:0]       r_idx, n_idx;
    logic [ccce_pkg::CompW-1:0]      r_comp, n_comp;
    logic [ccce_pkg::CornerW-1:0]    r_cur, n_cur;
    logic [ccce_pkg::NbrW-1:0]       r_nb, n_nb;
    logic [ccce_pkg::SpW-1:0]        r_sp, n_sp;
    logic [ccce_pkg::CornerW+ccce_pkg::NbrW-1:0] r_stk [ccce_pkg::StackDepth];
    logic                            w_push;
    ccce_pkg::t_edge                 r_pend, n_pend;
    logic                            r_pend_v, n_pend_v;
    ccce_pkg::t_edge                 r_out, n_out;
    logic                            r_out_last, n_out_last;
    logic                            r_out_v, n_out_v;

    logic                            w_out_free;
    logic [ccce_pkg::CornerW-1:0]    w_adj;
    logic [ccce_pkg::CornerW-1:0]    w_sel;
    logic [ccce_pkg::SpW-1:0]        w_sp_top;
    logic [ccce_pkg::CornerW+ccce_pkg::NbrW-1:0] w_top;
    logic                            w_cand;
    logic [CntW-1:0]                 w_cnt;
    ccce_pkg::t_edge                 w_edge;

    always_comb begin
        w_out_free = !r_out_v || i_out_ready;
        w_sel      = r_idx[ccce_pkg::CornerW-1:0];
        w_adj      = r_cur ^ (ccce_pkg::CornerW'(1) << r_nb);
        w_sp_top   = r_sp - ccce_pkg::SpW'(1);
        w_top      = r_stk[w_sp_top];
        w_cand     = (r_act[w_sel] == r_want) && !r_seen[w_sel];
        w_cnt      = '0;
        for (int k = 0; k < ccce_pkg::NumCorners; k++) begin
            w_cnt = w_cnt + CntW'(r_act[k]);
        end
        // the active end always goes first
        w_edge.comp  = r_comp;
        w_edge.act   = r_want ? r_cur : w_adj;
        w_edge.inact = r_want ? w_adj : r_cur;

        n_act      = r_act;
        n_seen     = r_seen;
        n_want     = r_want;
        n_idx      = r_idx;
        n_comp     = r_comp;
        n_cur      = r_cur;
        n_nb       = r_nb;
        n_sp       = r_sp;
        w_push     = 1'b0;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !i_out_ready;

        o_status.in_valid  = i_in_valid;
        o_status.uniform   = (r_act == '0) || (r_act == '1);
        o_status.scan_end  = r_idx[ccce_pkg::IdxW-1];
        o_status.cand      = w_cand;
        o_status.comp_done = (r_nb == ccce_pkg::NbrW'(3)) && (r_sp == '0);
        o_status.flushed   = !r_pend_v || w_out_free;

        unique case (i_op)
            ccce_pkg::OP_LOAD: begin
                if (i_in_valid) begin
                    for (int k = 0; k < ccce_pkg::NumCorners; k++) begin
                        n_act[k] = (i_corner[k] >= r_iso);
                    end
                end
            end
            ccce_pkg::OP_CLASS: begin
                n_want   = (w_cnt <= CntW'(ccce_pkg::HalfCorners));
                n_seen   = '0;
                n_idx    = '0;
                n_comp   = '0;
                n_pend_v = 1'b0;
            end
            ccce_pkg::OP_START: begin
                if (w_cand) begin
                    n_seen[w_sel] = 1'b1;
                    n_cur         = w_sel;
                    n_nb          = '0;
                    n_sp          = '0;
                end else begin
                    n_idx = r_idx + ccce_pkg::IdxW'(1);
                end
            end
            ccce_pkg::OP_WALK: begin
                if (r_nb == ccce_pkg::NbrW'(3)) begin
                    if (r_sp == '0) begin
                        // component finished, resume the corner scan
                        n_comp = r_comp + ccce_pkg::CompW'(1);
                        n_idx  = r_idx + ccce_pkg::IdxW'(1);
                    end else begin
                        n_sp  = w_sp_top;
                        n_cur = w_top[ccce_pkg::CornerW+ccce_pkg::NbrW-1:ccce_pkg::NbrW];
                        n_nb  = w_top[ccce_pkg::NbrW-1:0] + ccce_pkg::NbrW'(1);
                    end
                end else if (r_act[w_adj] == r_want) begin
                    if (!r_seen[w_adj]) begin
                        w_push        = 1'b1;
                        n_sp          = r_sp + ccce_pkg::SpW'(1);
                        n_cur         = w_adj;
                        n_nb          = '0;
                        n_seen[w_adj] = 1'b1;
                    end else begin
                        n_nb = r_nb + ccce_pkg::NbrW'(1);
                    end
                end else if (!r_pend_v) begin
                    n_pend   = w_edge;
                    n_pend_v = 1'b1;
                    n_nb     = r_nb + ccce_pkg::NbrW'(1);
                end else if (w_out_free) begin
                    // older word is known not to be last
                    n_out      = r_pend;
                    n_out_last = 1'b0;
                    n_out_v    = 1'b1;
                    n_pend     = w_edge;
                    n_nb       = r_nb + ccce_pkg::NbrW'(1);
                end
            end
            ccce_pkg::OP_FLUSH: begin
                if (r_pend_v && w_out_free) begin
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_iso <= i_cfg_data;
            end
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_seen     <= n_seen;
        r_want     <= n_want;
        r_idx      <= n_idx;
        r_comp     <= n_comp;
        r_cur      <= n_cur;
        r_nb       <= n_nb;
        r_sp       <= n_sp;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        if (w_push) begin
            r_stk[r_sp] <= {r_cur, r_nb};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_edge  = r_out;
    assign o_out_last  = r_out_last;

endmodule

// ===== src/cube_corner_component_edges_core.sv =====
// top level of the cube corner component edges block
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | i_in_valid/o_in_ready   | eight signed Q8.8 corner samples
//  out     | output    | o_out_valid/i_out_ready | component, active/inactive corner, last
//  cfg     | input     | i_cfg_valid/o_cfg_ready | iso level, signed Q8.8
//
// the sequencer runs one datapath step per cycle: a uniform cube runs only the load and
// classify steps; a cube with crossed edges also runs a scan and a test step per scanned
// corner, a walk step per neighbour of each visited corner plus one to leave it, and a flush
// reset is synchronous, active low; it clears the iso level and all valid flags
// a stalled output holds the walk or the flush when the pending and output words are both full
// the next cube is taken once the final word of the current one moves into the output register
module cube_corner_component_edges_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // cube input
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [15:0]     i_corner_0,
    input  logic signed [15:0]     i_corner_1,
    input  logic signed [15:0]     i_corner_2,
    input  logic signed [15:0]     i_corner_3,
    input  logic signed [15:0]     i_corner_4,
    input  logic signed [15:0]     i_corner_5,
    input  logic signed [15:0]     i_corner_6,
    input  logic signed [15:0]     i_corner_7,
    // iso level write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic signed [15:0]     i_cfg_data,
    // crossed edges
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_component_index,
    output logic [2:0]             o_active_corner,
    output logic [2:0]             o_inactive_corner,
    output logic                   o_last_edge
);

    ccce_pkg::t_uop    w_op;
    ccce_pkg::t_status w_status;
    ccce_pkg::t_sample w_corner [ccce_pkg::NumCorners];
    ccce_pkg::t_edge   w_edge;

    // gather corner samples in index order
    assign w_corner[0] = i_corner_0;
    assign w_corner[1] = i_corner_1;
    assign w_corner[2] = i_corner_2;
    assign w_corner[3] = i_corner_3;
    assign w_corner[4] = i_corner_4;
    assign w_corner[5] = i_corner_5;
    assign w_corner[6] = i_corner_6;
    assign w_corner[7] = i_corner_7;

    // the load step is the only one that takes a cube
    assign o_in_ready  = (w_op == ccce_pkg::OP_LOAD);
    // register writes land at once; they are to be done only while idle, the block itself does not enforce it
    assign o_cfg_ready = 1'b1;

    ccce_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    ccce_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_in_valid  (i_in_valid),
        .i_corner    (w_corner),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_edge  (w_edge),
        .o_out_last  (o_last_edge)
    );

    assign o_component_index = w_edge.comp;
    assign o_active_corner   = w_edge.act;
    assign o_inactive_corner = w_edge.inact;

endmodule

// ===== tb/tb.sv =====
// testbench for the cube corner component edges block: directed and random cubes
module tb;

    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 60;
    localparam int IdlePercent  = 31;
    localparam int MaxCrossings = 12;

    typedef logic [ccce_pkg::NumCorners-1:0][ccce_pkg::SampleW-1:0] t_cube;

    typedef struct {
        logic [ccce_pkg::CompW-1:0]   comp;
        logic [ccce_pkg::CornerW-1:0] act;
        logic [ccce_pkg::CornerW-1:0] inact;
        logic                         last;
    } t_crossing;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [15:0]   i_corner_0 = '0;
    logic signed [15:0]   i_corner_1 = '0;
    logic signed [15:0]   i_corner_2 = '0;
    logic signed [15:0]   i_corner_3 = '0;
    logic signed [15:0]   i_corner_4 = '0;
    logic signed [15:0]   i_corner_5 = '0;
    logic signed [15:0]   i_corner_6 = '0;
    logic signed [15:0]   i_corner_7 = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic signed [15:0]   i_cfg_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_component_index;
    logic [2:0]           o_active_corner;
    logic [2:0]           o_inactive_corner;
    logic                 o_last_edge;

    t_crossing         pending_edges[$];
    ccce_pkg::t_sample iso_model = '0;
    int                mismatches = 0;
    int                cycle_count = 0;
    int                hold_request = 0;
    int                stall_left = 0;
    bit                steady = 1'b0;

    cube_corner_component_edges_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_corner_0        (i_corner_0),
        .i_corner_1        (i_corner_1),
        .i_corner_2        (i_corner_2),
        .i_corner_3        (i_corner_3),
        .i_corner_4        (i_corner_4),
        .i_corner_5        (i_corner_5),
        .i_corner_6        (i_corner_6),
        .i_corner_7        (i_corner_7),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_component_index (o_component_index),
        .o_active_corner   (o_active_corner),
        .o_inactive_corner (o_inactive_corner),
        .o_last_edge       (o_last_edge)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[cube_corner_component_edges_core] ERROR");
            $finish;
        end
    end

    // classify the corners, then walk each minority group depth first
    function automatic void predict_crossings(input t_cube cube);
        logic [7:0]                   act_bits;
        logic [7:0]                   seen;
        logic                         minority;
        logic [ccce_pkg::CornerW-1:0] node_stk [8];
        int                           try_stk [8];
        logic [ccce_pkg::CornerW-1:0] node;
        logic [ccce_pkg::CornerW-1:0] adj;
        int                           n_act;
        int                           sp;
        int                           comp;
        int                           found;
        t_crossing                    word;
        act_bits = '0;
        n_act = 0;
        for (int c = 0; c < ccce_pkg::NumCorners; c++) begin
            if ($signed(cube[c]) >= iso_model) begin
                act_bits[c] = 1'b1;
                n_act++;
            end
        end
        if (n_act == 0 || n_act == ccce_pkg::NumCorners)
            return;
        minority = (n_act <= ccce_pkg::HalfCorners);
        seen = '0;
        comp = 0;
        found = 0;
        for (int c = 0; c < ccce_pkg::NumCorners; c++) begin
            if (act_bits[c] == minority && !seen[c]) begin
                seen[c] = 1'b1;
                sp = 0;
                node_stk[0] = c[ccce_pkg::CornerW-1:0];
                try_stk[0] = 0;
                while (sp >= 0) begin
                    node = node_stk[sp];
                    if (try_stk[sp] == 3) begin
                        sp--;
                    end else begin
                        adj = node ^ (3'd1 << try_stk[sp]);
                        try_stk[sp]++;
                        if (act_bits[adj] == minority) begin
                            if (!seen[adj]) begin
                                seen[adj] = 1'b1;
                                sp++;
                                node_stk[sp] = adj;
                                try_stk[sp] = 0;
                            end
                        end else if (found < MaxCrossings) begin
                            word.comp  = comp[ccce_pkg::CompW-1:0];
                            word.act   = minority ? node : adj;
                            word.inact = minority ? adj : node;
                            word.last  = 1'b0;
                            pending_edges = {pending_edges, word};
                            found++;
                        end
                    end
                end
                comp++;
            end
        end
        if (found > 0)
            pending_edges[pending_edges.size()-1].last = 1'b1;
    endfunction

    function automatic t_cube cube_from_mask(input logic [7:0] mask,
                                             input ccce_pkg::t_sample up,
                                             input ccce_pkg::t_sample down);
        t_cube cube;
        for (int c = 0; c < ccce_pkg::NumCorners; c++)
            cube[c] = mask[c] ? up : down;
        return cube;
    endfunction

    // mostly samples placed on a chosen side of the level, some raw noise
    function automatic t_cube random_cube();
        t_cube      cube;
        logic [7:0] mask;
        int         pick;
        int         lo;
        int         hi;
        int         r;
        pick = $urandom_range(99);
        if (pick < 4)
            mask = 8'h00;
        else if (pick < 8)
            mask = 8'hFF;
        else
            mask = 8'($urandom_range(255));
        for (int c = 0; c < ccce_pkg::NumCorners; c++) begin
            if (pick >= 92) begin
                cube[c] = 16'($urandom_range(65535));
            end else begin
                // nothing lies below the lowest level
                if (iso_model == -32768)
                    mask[c] = 1'b1;
                lo = mask[c] ? int'(iso_model) : -32768;
                hi = mask[c] ? 32767 : int'(iso_model) - 1;
                r = $urandom_range(9);
                if (r < 2)
                    cube[c] = 16'(mask[c] ? lo : hi);
                else if (r == 2)
                    cube[c] = 16'(mask[c] ? hi : lo);
                else
                    cube[c] = 16'(lo + $urandom_range(hi - lo));
            end
        end
        return cube;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cube(input t_cube cube);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IdlePercent) begin
            if (gap == 0)
                i_in_valid <= 1'b0;
            gap++;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_corner_0 <= cube[0];
        i_corner_1 <= cube[1];
        i_corner_2 <= cube[2];
        i_corner_3 <= cube[3];
        i_corner_4 <= cube[4];
        i_corner_5 <= cube[5];
        i_corner_6 <= cube[6];
        i_corner_7 <= cube[7];
        do @(posedge i_clk); while (!o_in_ready);
        predict_crossings(cube);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_cube(random_cube());
    endtask

    task automatic set_iso(input ccce_pkg::t_sample level);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= level;
        do @(posedge i_clk); while (!o_cfg_ready);
        iso_model = level;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender stops until every crossed edge is back, then the block settles
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic test_directed();
        set_iso(16'sd0);
        send_cube(cube_from_mask(8'h00, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'hFF, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'h01, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'h7F, 16'sh7FFF, -16'sd32768));
        // four active on one face, then four isolated corners
        send_cube(cube_from_mask(8'h0F, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'h69, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'h96, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'h81, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'h7E, 16'sh7FFF, -16'sd32768));
        send_cube(cube_from_mask(8'h1F, 16'sh7FFF, -16'sd32768));
        // samples right on and just below the level
        send_cube(cube_from_mask(8'h17, 16'sd0, -16'sd1));
        send_cube(cube_from_mask(8'hE8, 16'sd0, -16'sd1));
        wait_drained();
        set_iso(16'sh7FFF);
        send_cube(cube_from_mask(8'h10, 16'sh7FFF, 16'sh7FFE));
        send_cube(cube_from_mask(8'hFF, 16'sh7FFF, 16'sh7FFE));
        wait_drained();
        set_iso(-16'sd32768);
        send_cube(cube_from_mask(8'h00, 16'sh7FFF, -16'sd32768));
        send_cube(random_cube());
        wait_drained();
    endtask

    task automatic test_levels();
        ccce_pkg::t_sample levels [6];
        levels[0] = 16'sh0100;
        levels[1] = -16'sh0100;
        levels[2] = ccce_pkg::t_sample'($urandom_range(65535));
        levels[3] = ccce_pkg::t_sample'($urandom_range(65535));
        levels[4] = 16'sh7FFF;
        levels[5] = -16'sd32768;
        for (int k = 0; k < 6; k++) begin
            set_iso(levels[k]);
            send_random(levels[k] == -16'sd32768 ? 10 : 72);
            wait_drained();
        end
    endtask

    // output held off while the input keeps offering cubes
    task automatic test_backpressure();
        set_iso(16'sd0);
        hold_request = 400;
        steady = 1'b1;
        send_random(40);
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_steady();
        set_iso(ccce_pkg::t_sample'($urandom_range(65535)));
        steady = 1'b1;
        send_random(50);
        steady = 1'b0;
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= IdlePercent);
        end
    end

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_edges.size() == 0) begin
                $error("unexpected word: comp %0d act %0d inact %0d last %0d",
                       o_component_index, o_active_corner, o_inactive_corner, o_last_edge);
                mismatches++;
            end else begin
                want = pending_edges.pop_front();
                if (o_component_index !== want.comp) begin
                    $error("component_index: expected %0d, actual %0d",
                           want.comp, o_component_index);
                    mismatches++;
                end
                if (o_active_corner !== want.act) begin
                    $error("active_corner: expected %0d, actual %0d", want.act, o_active_corner);
                    mismatches++;
                end
                if (o_inactive_corner !== want.inact) begin
                    $error("inactive_corner: expected %0d, actual %0d",
                           want.inact, o_inactive_corner);
                    mismatches++;
                end
                if (o_last_edge !== want.last) begin
                    $error("last_edge: expected %0d, actual %0d", want.last, o_last_edge);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_levels();
        test_backpressure();
        test_steady();
        if (mismatches == 0)
            $display("[cube_corner_component_edges_core] OK");
        else
            $display("[cube_corner_component_edges_core] ERROR");
        $finish;
    end

endmodule
